// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/cmi_pkg.sv -----
package cmi_pkg;

  localparam logic [11:0] YearFirst = 12'd1601;
  localparam logic [11:0] YearLast  = 12'd3000;
  localparam logic [11:0] Span400   = 12'd400;
  localparam logic [8:0]  Mod400Top = 9'd399;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REDUCE,
    S_STEP,
    S_FIN
  } cmi_state_t;

  // Sequencer to datapath.
  typedef struct packed {
    logic load;
    logic reduce;
    logic step;
    logic fin;
  } cmi_ctrl_t;

  // Datapath to sequencer.
  typedef struct packed {
    logic rem_ge400;
    logic cur_lt_year;
  } cmi_stat_t;

  // Cumulative month offset reduced modulo 7; zero outside 1..12.
  function automatic logic [2:0] month_offset7(input logic [3:0] m);
    logic [2:0] r;
    unique case (m)
      4'd1:    r = 3'd0;
      4'd2:    r = 3'd3;
      4'd3:    r = 3'd3;
      4'd4:    r = 3'd6;
      4'd5:    r = 3'd1;
      4'd6:    r = 3'd4;
      4'd7:    r = 3'd6;
      4'd8:    r = 3'd2;
      4'd9:    r = 3'd5;
      4'd10:   r = 3'd0;
      4'd11:   r = 3'd3;
      4'd12:   r = 3'd5;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:    r = leap ? 5'd29 : 5'd28;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // Leap test from the low year bits and the year modulo 400.
  function automatic logic leap_of(input logic [1:0] y_low, input logic [8:0] y400);
    return (y_low == 2'd0) && (y400 != 9'd100) && (y400 != 9'd200) && (y400 != 9'd300);
  endfunction

endpackage

// ----- hw/rtl/cmi_seq.sv -----
module cmi_seq import cmi_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  cmi_stat_t stat,
  output cmi_ctrl_t ctrl,
  output logic      busy
);

  cmi_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    busy       = 1'b1;
    unique case (state)
      S_IDLE: begin
        busy      = 1'b0;
        ctrl.load = start;
        if (start) begin
          state_next = S_REDUCE;
        end
      end
      S_REDUCE: begin
        ctrl.reduce = 1'b1;
        if (!stat.rem_ge400) begin
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        ctrl.step = 1'b1;
        if (!stat.cur_lt_year) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        ctrl.fin   = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/cmi_datapath.sv -----
module cmi_datapath import cmi_pkg::*; (
  input  logic        clk,
  input  cmi_ctrl_t   ctrl,
  input  logic [4:0]  day,
  input  logic [3:0]  month,
  input  logic [11:0] year,
  output cmi_stat_t   stat,
  output logic [4:0]  day_q,
  output logic [3:0]  month_q,
  output logic [11:0] year_q,
  output logic        leap_q,
  output logic [2:0]  weekday
);

  logic [11:0] rem;     // year reduced modulo 400 by repeated subtraction
  logic [11:0] cur;     // year being stepped
  logic [8:0]  cur400;  // cur modulo 400
  logic [2:0]  acc;     // weekday accumulator modulo 7

  logic [3:0]  addend;
  logic [3:0]  sum;
  logic [2:0]  sum7;
  logic        cur_leap;

  assign cur_leap = leap_of(cur[1:0], cur400);
  assign leap_q   = leap_of(year_q[1:0], rem[8:0]);

  // The one mod-7 adder serves both the year stepping and the month correction.
  always_comb begin
    if (ctrl.fin) begin
      addend = {1'b0, month_offset7(month_q)} + {3'b0, leap_q && (month_q >= 4'd3)};
    end else begin
      addend = {3'b0, 1'b1} + {3'b0, cur_leap};
    end
    sum  = {1'b0, acc} + addend;
    sum7 = (sum >= 4'd7) ? 3'(sum - 4'd7) : sum[2:0];
  end

  assign weekday          = sum7;
  assign stat.rem_ge400   = rem >= Span400;
  assign stat.cur_lt_year = cur < year_q;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      day_q   <= day;
      month_q <= month;
      year_q  <= year;
      rem     <= year;
      cur     <= YearFirst;
      cur400  <= 9'(YearFirst % 400);
      acc     <= 3'd0;
    end else if (ctrl.reduce) begin
      if (stat.rem_ge400) begin
        rem <= rem - Span400;
      end
    end else if (ctrl.step) begin
      if (stat.cur_lt_year) begin
        acc    <= sum7;
        cur    <= cur + 12'd1;
        cur400 <= (cur400 == Mod400Top) ? 9'd0 : cur400 + 9'd1;
      end
    end
  end

endmodule

// ----- hw/rtl/calendar_month_info_unit.sv -----
// Month information for a Gregorian date. Raise start while busy is low to
// hand in one word (day, month, year); busy rises on the next cycle and stays
// high until the result word appears, for one cycle only, with done high. The
// receiver cannot stall, so capture the result on that cycle. The sequencer
// first reduces the year modulo 400 by repeated subtraction and then steps
// one year per cycle from 1601 through the shared modulo-7 adder.
module calendar_month_info_unit import cmi_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [4:0]        day,
  input  logic [3:0]        month,
  input  logic [11:0]       year,
  output logic              done,
  output logic              date_valid,
  output logic              leap_year,
  output logic [4:0]        days_in_month,
  output logic [2:0]        first_weekday,
  output logic              two_months,
  output logic signed [6:0] carry_count,
  output logic [3:0]        next_month,
  output logic [11:0]       next_year
);

  cmi_ctrl_t   ctrl;
  cmi_stat_t   stat;
  logic [4:0]  day_q;
  logic [3:0]  month_q;
  logic [11:0] year_q;
  logic        leap_q;
  logic [2:0]  weekday;
  logic        start_ok;

  logic [4:0]  dim;
  logic [6:0]  carry;

  assign start_ok = start && !busy;

  cmi_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start_ok),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  cmi_datapath u_dp (
    .clk     (clk),
    .ctrl    (ctrl),
    .day     (day),
    .month   (month),
    .year    (year),
    .stat    (stat),
    .day_q   (day_q),
    .month_q (month_q),
    .year_q  (year_q),
    .leap_q  (leap_q),
    .weekday (weekday)
  );

  assign dim   = month_days(month_q, leap_q);
  assign carry = {2'b00, dim} - {2'b00, day_q} + 7'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fin) begin
      date_valid    <= (year_q >= YearFirst) && (year_q <= YearLast) && (dim != 5'd0)
                       && (day_q != 5'd0) && (day_q <= dim);
      leap_year     <= leap_q;
      days_in_month <= dim;
      first_weekday <= weekday;
      // Fewer than nine days left is the same as a carry below ten.
      two_months    <= $signed(carry) < 7'sd10;
      carry_count   <= $signed(carry);
      next_month    <= (month_q == 4'd12) ? 4'd1 : month_q + 4'd1;
      next_year     <= (month_q == 4'd12) ? year_q + 12'd1 : year_q;
    end
  end

endmodule

// ----- hw/rtl/cmi_checker.sv -----
`include "assert_macros.svh"

module cmi_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic              date_valid,
  input logic [4:0]        days_in_month,
  input logic [2:0]        first_weekday,
  input logic signed [6:0] carry_count
);

  // An accepted word always raises busy in the following cycle.
  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  // The result word shows only once the sequencer has returned to idle.
  `ASSERT_SAME(a_done_idle, clk, rst, done, !busy)
  `ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  // The weekday is a residue modulo seven.
  `ASSERT_SAME(a_weekday_range, clk, rst, done, first_weekday != 3'd7)
  // A valid date has a real month and leaves a positive carry.
  `ASSERT_SAME(a_valid_month, clk, rst, done && date_valid,
               (days_in_month >= 5'd28) && (carry_count > 7'sd0))

endmodule

bind calendar_month_info_unit cmi_checker u_cmi_checker (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;

  localparam int FIRST_YEAR  = 1601;
  localparam int LAST_YEAR   = 3000;
  localparam int FEBRUARY    = 2;
  localparam int MARCH       = 3;
  localparam int DECEMBER    = 12;
  localparam int CYCLE_LIMIT = 6_000_000;
  localparam int TAIL_CYCLES = 40;

  // Days from January 1 to the first of each month, in a common year, up to a multiple of seven.
  localparam int CUM_DAYS [0:12] = '{0, 0, 3, 3, 6, 8, 11, 13, 16, 19, 21, 24, 26};

  typedef struct packed {
    logic        date_valid;
    logic        leap_year;
    logic [4:0]  days_in_month;
    logic [2:0]  first_weekday;
    logic        two_months;
    logic [6:0]  carry_count;
    logic [3:0]  next_month;
    logic [11:0] next_year;
  } month_report_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [4:0]        day;
  logic [3:0]        month;
  logic [11:0]       year;
  logic              done;
  logic              date_valid;
  logic              leap_year;
  logic [4:0]        days_in_month;
  logic [2:0]        first_weekday;
  logic              two_months;
  logic signed [6:0] carry_count;
  logic [3:0]        next_month;
  logic [11:0]       next_year;

  month_report_t pending_reports[$];
  int            mismatch_count = 0;
  int            cycle_count    = 0;

  calendar_month_info_unit uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .day           (day),
    .month         (month),
    .year          (year),
    .done          (done),
    .date_valid    (date_valid),
    .leap_year     (leap_year),
    .days_in_month (days_in_month),
    .first_weekday (first_weekday),
    .two_months    (two_months),
    .carry_count   (carry_count),
    .next_month    (next_month),
    .next_year     (next_year)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit gregorian_leap(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int leaps_through(input int n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  function automatic int length_of_month(input int m, input bit leap);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      FEBRUARY:              return leap ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic month_report_t predict_month(input logic [4:0] d, input logic [3:0] m,
                                                  input logic [11:0] y);
    month_report_t r;
    int  dy, mo, yr, dim, acc, rem;
    bit  leap;
    dy   = d;
    mo   = m;
    yr   = y;
    leap = gregorian_leap(yr);
    dim  = length_of_month(mo, leap);
    acc  = 0;
    // Each elapsed year shifts the weekday by one, a leap year by two.
    if (yr > FIRST_YEAR)
      acc = (yr - FIRST_YEAR) + leaps_through(yr - 1) - leaps_through(FIRST_YEAR - 1);
    if (mo >= 1 && mo <= DECEMBER)
      acc += CUM_DAYS[mo];
    if (leap && mo >= MARCH)
      acc += 1;
    rem = dim - dy;
    r.date_valid    = (yr >= FIRST_YEAR) && (yr <= LAST_YEAR) && (dim != 0)
                      && (dy >= 1) && (dy <= dim);
    r.leap_year     = leap;
    r.days_in_month = 5'(dim);
    r.first_weekday = 3'(acc % 7);
    r.two_months    = (rem < 9);
    r.carry_count   = 7'(rem + 1);
    r.next_month    = (mo == DECEMBER) ? 4'd1 : 4'(mo + 1);
    r.next_year     = (mo == DECEMBER) ? 12'(yr + 1) : y;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch on %s: got %0d, expected %0d", field, got, want);
    mismatch_count++;
  endtask

  task automatic compare_report(input month_report_t want);
    if (date_valid !== want.date_valid)
      report_mismatch("date_valid", date_valid, want.date_valid);
    if (leap_year !== want.leap_year)
      report_mismatch("leap_year", leap_year, want.leap_year);
    if (days_in_month !== want.days_in_month)
      report_mismatch("days_in_month", days_in_month, want.days_in_month);
    if (first_weekday !== want.first_weekday)
      report_mismatch("first_weekday", first_weekday, want.first_weekday);
    if (two_months !== want.two_months)
      report_mismatch("two_months", two_months, want.two_months);
    if (carry_count !== want.carry_count)
      report_mismatch("carry_count", carry_count, $signed(want.carry_count));
    if (next_month !== want.next_month)
      report_mismatch("next_month", next_month, want.next_month);
    if (next_year !== want.next_year)
      report_mismatch("next_year", next_year, want.next_year);
  endtask

  // A word is taken when start is high and busy is low at a rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy)
        pending_reports.push_back(predict_month(day, month, year));
      if (done) begin
        if (pending_reports.size() == 0)
          report_mismatch("unexpected done, words waiting", 1, 0);
        else
          compare_report(pending_reports.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Start is left high after acceptance; a following call or a gap decides its level.
  task automatic send_date(input int d, input int m, input int y);
    start <= 1'b1;
    day   <= 5'(d);
    month <= 4'(m);
    year  <= 12'(y);
    @(posedge clk);
    while (busy)
      @(posedge clk);
  endtask

  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 11)) @(posedge clk);
  endtask

  task automatic wait_all_reports();
    start <= 1'b0;
    do
      @(posedge clk);
    while (pending_reports.size() != 0);
  endtask

  // Most years stay close to 1601 so that the yearly stepping stays short.
  function automatic int random_year(input bit in_range);
    int r;
    r = $urandom_range(99);
    if (in_range)
      return (r < 80) ? $urandom_range(FIRST_YEAR, 1700) : $urandom_range(FIRST_YEAR, LAST_YEAR);
    if (r < 45)
      return $urandom_range(0, FIRST_YEAR - 1);
    if (r < 75)
      return $urandom_range(FIRST_YEAR, 1700);
    if (r < 92)
      return $urandom_range(FIRST_YEAR, LAST_YEAR);
    return $urandom_range(LAST_YEAR + 1, 4095);
  endfunction

  task automatic send_random_date();
    int yr, mo, dy;
    if ($urandom_range(99) < 70) begin
      yr = random_year(1'b1);
      mo = $urandom_range(1, DECEMBER);
      dy = $urandom_range(1, length_of_month(mo, gregorian_leap(yr)));
    end else begin
      yr = random_year(1'b0);
      mo = $urandom_range(0, 15);
      dy = $urandom_range(0, 31);
    end
    send_date(dy, mo, yr);
  endtask

  task automatic test_directed_dates();
    send_date(1, 1, FIRST_YEAR);
    send_date(0, 1, FIRST_YEAR);
    send_date(30, 11, 1602);
    send_date(31, DECEMBER, LAST_YEAR);
    send_date(1, 1, LAST_YEAR + 1);
    send_date(15, 6, FIRST_YEAR - 1);
    send_date(29, FEBRUARY, 2000);
    send_date(29, FEBRUARY, 1900);
    send_date(29, FEBRUARY, 2024);
    send_date(29, FEBRUARY, 2023);
    send_date(28, FEBRUARY, 2100);
    send_date(1, MARCH, 2400);
    send_date(31, 4, 1999);
    send_date(1, 0, 2000);
    send_date(5, 13, 2000);
    send_date(31, 15, 2024);
    send_date(22, 9, 2500);
    send_date(21, 9, 2500);
    send_date(0, 0, 0);
    send_date(31, DECEMBER, 4095);
    send_date(31, 15, 4095);
    idle_burst();
  endtask

  task automatic test_random_dates(input int count);
    repeat (count) begin
      send_random_date();
      if ($urandom_range(3) == 0)
        idle_burst();
    end
  endtask

  task automatic test_pause_until_drained();
    repeat (6) begin
      wait_all_reports();
      send_random_date();
    end
  endtask

  task automatic test_back_to_back(input int count);
    repeat (count) send_random_date();
    start <= 1'b0;
  endtask

  initial begin
    rst   <= 1'b1;
    start <= 1'b0;
    day   <= '0;
    month <= '0;
    year  <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_dates();
    test_random_dates(180);
    test_pause_until_drained();
    test_random_dates(170);
    test_back_to_back(60);

    wait_all_reports();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
